// ===== rtl/core/tbm_pkg.sv =====
// tbm_pkg: shared widths, constants and types of the two-rate byte meter.
// Used by the channel interfaces and every module under rtl/core.
package tbm_pkg;

	// Field and register widths
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned TIME_W      = 64;
	localparam int unsigned RATE_W      = 32;
	localparam int unsigned TOK_W       = 32;
	localparam int unsigned CFG_INDEX_W = 3;

	// Pipeline: stage 1 is the input register, the last stage the result register
	localparam int unsigned OUT_STAGE = 8;

	// Refill divisor 8000000 = 2^9 * 15625
	localparam logic [31:0] NS_KBPS_DIVISOR = 32'd8000000;
	localparam int unsigned DIV_SHIFT       = 9;
	localparam logic [13:0] DIV_ODD         = 14'd15625;

	// Scaled product width ahead of the odd divide, and its reciprocal
	localparam int unsigned X_W         = 46;
	localparam int unsigned RECIP_SHIFT = 46;
	localparam logic [32:0] RECIP       = 33'((64'd1 << RECIP_SHIFT) / 64'd15625);

	// Products at or above this value give a quotient of 2^32 or more
	localparam logic [64:0] SAT_LIMIT = {1'b0, NS_KBPS_DIVISOR, 32'd0};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PRESENT      = 3'd0,
		CFG_PEAK_RATE    = 3'd1,
		CFG_COMMIT_RATE  = 3'd2,
		CFG_PEAK_BURST   = 3'd3,
		CFG_COMMIT_BURST = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		COLOR_GREEN  = 2'd0,
		COLOR_YELLOW = 2'd1,
		COLOR_RED    = 2'd2
	} color_t;

	typedef logic [OUT_STAGE:1] stage_vec_t;

	// Per-word side data that rides along the pipeline
	typedef struct packed {
		logic             present;
		logic [LEN_W-1:0] len;
	} carry_t;

	// Control handed to the bucket stage
	typedef struct packed {
		logic   load;
		carry_t carry;
	} mark_ctl_t;

endpackage

// ===== rtl/core/tbm_ifs.sv =====
// tbm_ifs: valid/ready channel interfaces for packets in and colors out.
// Depends on tbm_pkg.
interface tbm_in_if;
	import tbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [LEN_W-1:0]  packet_length;
	logic [TIME_W-1:0] arrival_time_ns;

	modport source (output valid, output packet_length, output arrival_time_ns, input ready);
	modport sink (input valid, input packet_length, input arrival_time_ns, output ready);
endinterface

interface tbm_out_if;
	import tbm_pkg::*;
	logic   valid;
	logic   ready;
	color_t color;

	modport source (output valid, output color, input ready);
	modport sink (input valid, input color, output ready);
endinterface

// ===== rtl/core/two_rate_byte_meter.sv =====
// two_rate_byte_meter: color-blind two-rate three-color meter in byte mode.
// Depends on tbm_pkg, tbm_ifs, tbm_refill and tbm_marker.
//
//   channel   dir  payload                          handshake
//   pkt       in   packet_length, arrival_time_ns   valid/ready
//   verdict   out  color                            valid/ready
//   cfg       in   cfg_index, cfg_wdata             cfg_we, no wait
//
// One word per cycle when the output does not stall; eight register stages,
// the last of them the result register that holds the color.
// The pipeline depth is set by the refill chain per bucket: two partial products,
// a reciprocal multiply for the divide by 15625 and a multiply-back check.
// The token update closes its loop within the last stage.
// Reset clears configuration, last arrival time and both buckets at once.
// Stalls back up stage by stage; empty stages close up, so input is taken
// while the output register holds, as long as some stage is empty.
module two_rate_byte_meter (
	input  logic                              clk,
	input  logic                              arst_n,
	tbm_in_if.sink                            pkt,
	tbm_out_if.source                         verdict,
	input  logic                              cfg_we,
	input  logic [tbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tbm_pkg::RATE_W-1:0]        cfg_wdata
);
	import tbm_pkg::*;

	logic              present_q;
	logic [RATE_W-1:0] peak_rate_q, commit_rate_q;
	logic [TOK_W-1:0]  peak_burst_q, commit_burst_q;
	logic [TIME_W-1:0] last_q;
	stage_vec_t        valid_q;
	stage_vec_t        en;
	logic              accept;
	logic [TIME_W-1:0] elapsed_s1;
	carry_t            carry_s [1:OUT_STAGE-1];
	logic [TOK_W-1:0]  peak_refill_s7, commit_refill_s7;
	mark_ctl_t         mark_ctl;
	color_t            color_s8;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q      <= 1'b0;
			peak_rate_q    <= '0;
			commit_rate_q  <= '0;
			peak_burst_q   <= '0;
			commit_burst_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PRESENT:      present_q      <= cfg_wdata[0];
				CFG_PEAK_RATE:    peak_rate_q    <= cfg_wdata;
				CFG_COMMIT_RATE:  commit_rate_q  <= cfg_wdata;
				CFG_PEAK_BURST:   peak_burst_q   <= cfg_wdata;
				CFG_COMMIT_BURST: commit_burst_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage enables: a stage advances when it is empty or the next one advances
	always_comb begin
		en[OUT_STAGE] = !valid_q[OUT_STAGE] || verdict.ready;
		for (int k = OUT_STAGE - 1; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	assign pkt.ready = en[1];
	assign accept    = pkt.valid && en[1];

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= pkt.valid;
			end
			for (int k = 2; k <= OUT_STAGE; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Track the arrival time of the last metered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (accept && present_q) begin
			last_q <= pkt.arrival_time_ns;
		end
	end

	// Input register and side data shift
	always_ff @(posedge clk) begin
		if (en[1]) begin
			elapsed_s1         <= pkt.arrival_time_ns - last_q;
			carry_s[1].present <= present_q;
			carry_s[1].len     <= pkt.packet_length;
		end
		for (int k = 2; k <= OUT_STAGE - 1; k++) begin
			if (en[k]) begin
				carry_s[k] <= carry_s[k-1];
			end
		end
	end

	tbm_refill u_peak_refill (
		.clk        (clk),
		.en         (en),
		.elapsed_s1 (elapsed_s1),
		.rate       (peak_rate_q),
		.refill_s7  (peak_refill_s7)
	);

	tbm_refill u_commit_refill (
		.clk        (clk),
		.en         (en),
		.elapsed_s1 (elapsed_s1),
		.rate       (commit_rate_q),
		.refill_s7  (commit_refill_s7)
	);

	assign mark_ctl.load  = en[OUT_STAGE] && valid_q[OUT_STAGE-1];
	assign mark_ctl.carry = carry_s[OUT_STAGE-1];

	tbm_marker u_marker (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (mark_ctl),
		.peak_refill_s7   (peak_refill_s7),
		.commit_refill_s7 (commit_refill_s7),
		.peak_burst       (peak_burst_q),
		.commit_burst     (commit_burst_q),
		.color_s8         (color_s8)
	);

	assign verdict.valid = valid_q[OUT_STAGE];
	assign verdict.color = color_s8;

endmodule

// ===== rtl/core/tbm_refill.sv =====
// tbm_refill: pipelined refill amount floor(elapsed * rate / 8000000), saturated to 32 bits.
// Stages 2 to 7 of the meter pipeline. Depends on tbm_pkg.
module tbm_refill (
	input  logic                         clk,
	input  tbm_pkg::stage_vec_t          en,
	input  logic [tbm_pkg::TIME_W-1:0]   elapsed_s1,
	input  logic [tbm_pkg::RATE_W-1:0]   rate,
	output logic [tbm_pkg::TOK_W-1:0]    refill_s7
);
	import tbm_pkg::*;

	logic [63:0]      prod_lo_s2;
	logic [63:0]      prod_hi_s2;
	logic [64:0]      wide_sum;
	logic             sat_s3, sat_s4, sat_s5, sat_s6;
	logic [X_W-1:0]   x_s3, x_s4, x_s5, x_s6;
	logic [64:0]      pp_lo_s4;
	logic [46:0]      pp_hi_s4;
	logic [79:0]      est_sum;
	logic [31:0]      q_est_s5, q_est_s6;
	logic [X_W-1:0]   back_s6;
	logic [X_W-1:0]   rem;

	// Stage 2: split the 64x32 product into two 32x32 partial products
	always_ff @(posedge clk) begin
		if (en[2]) begin
			prod_lo_s2 <= 64'(elapsed_s1[31:0]) * 64'(rate);
			prod_hi_s2 <= 64'(elapsed_s1[63:32]) * 64'(rate);
		end
	end

	// Stage 3: detect saturation, drop the power-of-two part of the divisor
	assign wide_sum = {10'd0, prod_hi_s2[22:0], 32'd0} + {1'b0, prod_lo_s2};

	always_ff @(posedge clk) begin
		if (en[3]) begin
			sat_s3 <= (prod_hi_s2 >= 64'(NS_KBPS_DIVISOR)) || (wide_sum >= SAT_LIMIT);
			x_s3   <= wide_sum[DIV_SHIFT +: X_W];
		end
	end

	// Stage 4: multiply by the reciprocal of 15625 in two pieces
	always_ff @(posedge clk) begin
		if (en[4]) begin
			pp_lo_s4 <= 65'(x_s3[31:0]) * 65'(RECIP);
			pp_hi_s4 <= 47'(x_s3[X_W-1:32]) * 47'(RECIP);
			x_s4     <= x_s3;
			sat_s4   <= sat_s3;
		end
	end

	// Stage 5: combine the pieces; the estimate is the quotient or one short
	assign est_sum = {15'd0, pp_lo_s4} + {1'b0, pp_hi_s4, 32'd0};

	always_ff @(posedge clk) begin
		if (en[5]) begin
			q_est_s5 <= est_sum[RECIP_SHIFT +: 32];
			x_s5     <= x_s4;
			sat_s5   <= sat_s4;
		end
	end

	// Stage 6: multiply the estimate back
	always_ff @(posedge clk) begin
		if (en[6]) begin
			back_s6  <= X_W'(q_est_s5) * X_W'(DIV_ODD);
			q_est_s6 <= q_est_s5;
			x_s6     <= x_s5;
			sat_s6   <= sat_s5;
		end
	end

	// Stage 7: correct the estimate by one, or saturate
	assign rem = x_s6 - back_s6;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			if (sat_s6) begin
				refill_s7 <= '1;
			end else if (rem >= X_W'(DIV_ODD)) begin
				refill_s7 <= q_est_s6 + 32'd1;
			end else begin
				refill_s7 <= q_est_s6;
			end
		end
	end

endmodule

// ===== rtl/core/tbm_marker.sv =====
// tbm_marker: token buckets and color decision, the final pipeline stage.
// Holds the peak and committed token counts. Depends on tbm_pkg.
module tbm_marker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tbm_pkg::mark_ctl_t          ctl,
	input  logic [tbm_pkg::TOK_W-1:0]   peak_refill_s7,
	input  logic [tbm_pkg::TOK_W-1:0]   commit_refill_s7,
	input  logic [tbm_pkg::TOK_W-1:0]   peak_burst,
	input  logic [tbm_pkg::TOK_W-1:0]   commit_burst,
	output tbm_pkg::color_t             color_s8
);
	import tbm_pkg::*;

	logic [TOK_W-1:0] ptok_q, ctok_q;
	logic [TOK_W:0]   psum, csum;
	logic [TOK_W-1:0] pcap, ccap, len_w;
	logic [TOK_W-1:0] ptok_next, ctok_next;
	color_t           color_next;

	// Refill, cap at burst, take length where it fits; red takes none
	always_comb begin
		psum  = {1'b0, ptok_q} + {1'b0, peak_refill_s7};
		csum  = {1'b0, ctok_q} + {1'b0, commit_refill_s7};
		pcap  = (psum > {1'b0, peak_burst}) ? peak_burst : psum[TOK_W-1:0];
		ccap  = (csum > {1'b0, commit_burst}) ? commit_burst : csum[TOK_W-1:0];
		len_w = TOK_W'(ctl.carry.len);
		if (len_w > pcap) begin
			color_next = COLOR_RED;
			ptok_next  = pcap;
			ctok_next  = ccap;
		end else if (len_w > ccap) begin
			color_next = COLOR_YELLOW;
			ptok_next  = pcap - len_w;
			ctok_next  = ccap;
		end else begin
			color_next = COLOR_GREEN;
			ptok_next  = pcap - len_w;
			ctok_next  = ccap - len_w;
		end
	end

	// Update buckets only for metered words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptok_q <= '0;
			ctok_q <= '0;
		end else if (ctl.load && ctl.carry.present) begin
			ptok_q <= ptok_next;
			ctok_q <= ctok_next;
		end
	end

	// Result register; no meter means red
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			color_s8 <= ctl.carry.present ? color_next : COLOR_RED;
		end
	end

endmodule

// ===== rtl/core/tbm_checker.sv =====
// tbm_checker: port-level checks of the meter's handshakes, bound to the top level.
// Depends on tbm_pkg and two_rate_byte_meter.
module tbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pkt_ready,
	input logic       verdict_valid,
	input logic       verdict_ready,
	input logic [1:0] verdict_color
);
	import tbm_pkg::*;

	// A stalled result word stays
	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_ready |=> verdict_valid)
		else $error("verdict word dropped while stalled");

	// A stalled result word keeps its color
	a_color_stable: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_ready |=> $stable(verdict_color))
		else $error("verdict color changed while stalled");

	// Reset empties the result register
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !verdict_valid)
		else $error("verdict valid during reset");

	// An empty output means the pipeline can take a word
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!verdict_valid |-> pkt_ready)
		else $error("input blocked with empty output");

	// A draining output lets the input advance
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_ready |-> pkt_ready)
		else $error("input blocked while output drains");

endmodule

bind two_rate_byte_meter tbm_checker u_tbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pkt_ready     (pkt.ready),
	.verdict_valid (verdict.valid),
	.verdict_ready (verdict.ready),
	.verdict_color (verdict.color)
);
